/* sv/grd_pkg.sv */
package grd_pkg;

	// Grid geometry.
	localparam int GRID_W  = 16;
	localparam int GRID_H  = 16;
	localparam int CELLS   = GRID_W * GRID_H;
	localparam int CW      = $clog2(CELLS);
	localparam int SPW     = CW + 1;
	localparam int COORD_W = 4;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_START_X = 2'd0,
		REG_START_Y = 2'd1,
		REG_GOAL_X  = 2'd2,
		REG_GOAL_Y  = 2'd3
	} reg_idx_t;

	// Neighbor order: east, south, west, north.
	typedef enum logic [1:0] {
		DIR_E = 2'd0,
		DIR_S = 2'd1,
		DIR_W = 2'd2,
		DIR_N = 2'd3
	} dir_t;

	// Item function codes.
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// Linear cell number of an in-grid coordinate pair.
	function automatic logic [CW-1:0] cell_idx(input int x, input int y);
		return CW'(y * GRID_W + x);
	endfunction

endpackage

/* sv/grid_reachability_dfs.sv */
// Grid reachability engine with a depth-first search over a stored map.
// Input items (in_valid/in_ready): func selects the operation. A map write
// (func=0) stores the passable bit of cell (cell_x, cell_y) and gives no
// result; writes stream at one item per cycle while no search runs. A
// search item (func=1) gives one result item (out_valid/out_ready) saying
// whether the goal cell can be reached from the start cell.
// The start and goal cells come from the configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data), which is always ready.
// A search first sweeps the visited memory clear, then seeds the stack with
// the start cell and walks the grid: it pops a cell (POP, LOAD), probes
// each neighbor direction (PROBE) and checks each in-grid neighbor (EVAL).
// The walk ends when the stack is empty or the goal is reached, and the
// result is handed over from the done state. Searches with the start off
// the grid or equal to the goal skip the sweep and the walk. The walk
// is bound by the single read port of each memory.
// After reset the block clears the map memory and holds in_ready low
// meanwhile; all cells are then blocked.
// Results sit in an output register; when the receiver stalls, map writes
// still go on, and a finished search waits until that register is free.
module grid_reachability_dfs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [grd_pkg::COORD_W-1:0]   cell_x,
	input  logic [grd_pkg::COORD_W-1:0]   cell_y,
	input  logic                          passable,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          reachable,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [grd_pkg::COORD_W-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		ST_RST_CLR,
		ST_IDLE,
		ST_CLEAR,
		ST_SEED,
		ST_POP,
		ST_LOAD,
		ST_PROBE,
		ST_EVAL,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [grd_pkg::CW-1:0]          sweep_q;
	logic [grd_pkg::SPW-1:0]         sp_q;
	logic [grd_pkg::CW-1:0]          here_q;
	grd_pkg::dir_t                   dir_q;
	logic [grd_pkg::CW-1:0]          nb_q;
	logic                            nb_goal_q;
	logic                            res_q;
	logic                            out_valid_q;
	logic                            reachable_q;
	logic [grd_pkg::COORD_W-1:0]     start_x_q, start_y_q, goal_x_q, goal_y_q;

	// Memories and their ports.
	logic                            map_mem [grd_pkg::CELLS];
	logic                            vis_mem [grd_pkg::CELLS];
	logic [grd_pkg::CW-1:0]          stk_mem [grd_pkg::CELLS];
	logic                            map_rdata_q, vis_rdata_q;
	logic [grd_pkg::CW-1:0]          stk_rdata_q;
	logic                            map_we, vis_we, stk_we;
	logic [grd_pkg::CW-1:0]          map_waddr, vis_waddr, stk_waddr, stk_raddr;
	logic                            map_wdata, vis_wdata;
	logic [grd_pkg::CW-1:0]          stk_wdata;

	// Decoded helpers.
	logic                            in_acc;
	logic                            cell_in_grid, start_in_grid, start_is_goal;
	logic [grd_pkg::CW-1:0]          start_idx;
	logic [grd_pkg::SPW-1:0]         sp_dec;
	logic                            nb_ok, nb_is_goal, eval_take;
	logic [grd_pkg::CW-1:0]          nb_idx;
	int                              hx, hy, nx, ny;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign reachable = reachable_q;

	assign cell_in_grid  = (int'(cell_x) < grd_pkg::GRID_W) && (int'(cell_y) < grd_pkg::GRID_H);
	assign start_in_grid = (int'(start_x_q) < grd_pkg::GRID_W) &&
	                       (int'(start_y_q) < grd_pkg::GRID_H);
	assign start_is_goal = (start_x_q == goal_x_q) && (start_y_q == goal_y_q);
	assign start_idx     = grd_pkg::cell_idx(int'(start_x_q), int'(start_y_q));
	assign sp_dec        = sp_q - 1'b1;
	assign stk_raddr     = sp_dec[grd_pkg::CW-1:0];
	assign eval_take     = map_rdata_q && !vis_rdata_q;

	// Neighbor of the cell being expanded in the current direction.
	always_comb begin
		hx = int'(here_q) % grd_pkg::GRID_W;
		hy = int'(here_q) / grd_pkg::GRID_W;
		nx = hx;
		ny = hy;
		case (dir_q)
			grd_pkg::DIR_E: nx = hx + 1;
			grd_pkg::DIR_S: ny = hy + 1;
			grd_pkg::DIR_W: nx = hx - 1;
			grd_pkg::DIR_N: ny = hy - 1;
			default:        nx = hx;
		endcase
		nb_ok      = (nx >= 0) && (ny >= 0) && (nx < grd_pkg::GRID_W) && (ny < grd_pkg::GRID_H);
		nb_idx     = nb_ok ? grd_pkg::cell_idx(nx, ny) : '0;
		nb_is_goal = (nx == int'(goal_x_q)) && (ny == int'(goal_y_q));
	end

	// Memory write ports, selected by the current state.
	always_comb begin
		map_we    = 1'b0;
		map_waddr = sweep_q;
		map_wdata = 1'b0;
		vis_we    = 1'b0;
		vis_waddr = sweep_q;
		vis_wdata = 1'b0;
		stk_we    = 1'b0;
		stk_waddr = nb_q;
		stk_wdata = nb_q;
		case (state_q)
			ST_RST_CLR: begin
				map_we = 1'b1;
				vis_we = 1'b1;
			end
			ST_IDLE: begin
				map_we    = in_acc && (func == grd_pkg::FUNC_WRITE) && cell_in_grid;
				map_waddr = grd_pkg::cell_idx(int'(cell_x), int'(cell_y));
				map_wdata = passable;
			end
			ST_CLEAR: begin
				vis_we = 1'b1;
			end
			ST_SEED: begin
				vis_we    = 1'b1;
				vis_waddr = start_idx;
				vis_wdata = 1'b1;
				stk_we    = 1'b1;
				stk_waddr = '0;
				stk_wdata = start_idx;
			end
			ST_EVAL: begin
				vis_we    = eval_take && !nb_goal_q;
				vis_waddr = nb_q;
				vis_wdata = 1'b1;
				stk_we    = eval_take && !nb_goal_q && (sp_q < grd_pkg::SPW'(grd_pkg::CELLS));
				stk_waddr = sp_q[grd_pkg::CW-1:0];
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	// Map and visited memories: one write and one registered read a cycle.
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rdata_q <= map_mem[nb_idx];
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		vis_rdata_q <= vis_mem[nb_idx];
	end

	// Pending-cell stack memory.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		stk_rdata_q <= stk_mem[stk_raddr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			goal_x_q  <= 4'd15;
			goal_y_q  <= 4'd15;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				grd_pkg::REG_START_X: start_x_q <= cfg_data;
				grd_pkg::REG_START_Y: start_y_q <= cfg_data;
				grd_pkg::REG_GOAL_X:  goal_x_q  <= cfg_data;
				grd_pkg::REG_GOAL_Y:  goal_y_q  <= cfg_data;
				default:              start_x_q <= start_x_q;
			endcase
		end
	end

	// Search sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RST_CLR;
			sweep_q     <= '0;
			sp_q        <= '0;
			here_q      <= '0;
			dir_q       <= grd_pkg::DIR_E;
			nb_q        <= '0;
			nb_goal_q   <= 1'b0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
			reachable_q <= 1'b0;
		end else begin
			// The done state reloads the output register itself.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_RST_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == grd_pkg::CW'(grd_pkg::CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && (func == grd_pkg::FUNC_SEARCH)) begin
						sweep_q <= '0;
						if (!start_in_grid) begin
							res_q   <= 1'b0;
							state_q <= ST_DONE;
						end else if (start_is_goal) begin
							res_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == grd_pkg::CW'(grd_pkg::CELLS - 1)) begin
						state_q <= ST_SEED;
					end
				end
				ST_SEED: begin
					sp_q    <= grd_pkg::SPW'(1);
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (sp_q == '0) begin
						res_q   <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						sp_q    <= sp_dec;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					here_q  <= stk_rdata_q;
					dir_q   <= grd_pkg::DIR_E;
					state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					if (nb_ok) begin
						nb_q      <= nb_idx;
						nb_goal_q <= nb_is_goal;
						state_q   <= ST_EVAL;
					end else if (dir_q == grd_pkg::DIR_N) begin
						state_q <= ST_POP;
					end else begin
						dir_q <= grd_pkg::dir_t'(dir_q + 1'b1);
					end
				end
				ST_EVAL: begin
					if (eval_take && nb_goal_q) begin
						res_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						if (stk_we) begin
							sp_q <= sp_q + 1'b1;
						end
						if (dir_q == grd_pkg::DIR_N) begin
							state_q <= ST_POP;
						end else begin
							dir_q   <= grd_pkg::dir_t'(dir_q + 1'b1);
							state_q <= ST_PROBE;
						end
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						reachable_q <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/grd_checker.sv */
module grd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          func,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          reachable
);

	// A stalled result item holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reachable))
		else $error("result item changed while stalled");

	// A search keeps the input side closed in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == grd_pkg::FUNC_SEARCH) |=> !in_ready)
		else $error("input accepted right after a search item");

	// A map write leaves the input side open.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == grd_pkg::FUNC_WRITE) |=> in_ready)
		else $error("map write did not finish in one cycle");

	// A map write never produces a result item.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == grd_pkg::FUNC_WRITE) && !out_valid |=> !out_valid)
		else $error("result item appeared after a map write");

endmodule

bind grid_reachability_dfs grd_checker u_grd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.func      (func),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.reachable (reachable)
);
